// ===== design/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types, constants and codes for the fingerprint repair unit.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int NeighborsDef = 4;
  localparam int RefDepthDef  = 1024;
  localparam int ChannelsDef  = 36;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int DistW    = 50;
  localparam int RootW    = 25;
  localparam int WeightW  = 25;
  localparam int WsumW    = 30;
  localparam int AccW     = 62;

  localparam logic [CfgIdxW-1:0] CFG_REF_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RATIO     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FLOOR     = 2'd2;

  localparam logic [1:0] FUNC_LOAD_POS  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_FP   = 2'd1;
  localparam logic [1:0] FUNC_LOAD_MEAS = 2'd2;
  localparam logic [1:0] FUNC_RUN       = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         entry_index;
    logic [5:0]         channel_index;
    logic [31:0]        intensity;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
  } knn_in_t;

  typedef struct packed {
    logic [5:0]  channel_out;
    logic [31:0] repaired_intensity;
    logic        was_replaced;
    logic [5:0]  replaced_total;
    logic        last;
  } knn_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT,
    ST_WDIV,
    ST_ACC,
    ST_EDIV,
    ST_CMP,
    ST_EMIT
  } knn_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_load;    // capture the accepted item and perform a load
    logic run_start;  // clear neighbor list, latch query
    logic scan_step;  // advance the candidate scan
    logic root_start;
    logic root_step;
    logic wdiv_start;
    logic wdiv_step;
    logic acc_start;
    logic acc_step;
    logic ediv_start;
    logic ediv_step;
    logic cmp_step;
    logic emit;       // load output register
  } knn_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic root_done;
    logic wdiv_done;
    logic acc_done;
    logic ediv_done;
    logic nb_last;    // current neighbor slot is the last one
    logic ch_last;    // current channel is the last one
  } knn_sts_t;

endpackage

// ===== design/knn_ram.sv =====
// ----------------------------------------------------------------------------
// knn_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module knn_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/knn_ctrl.sv =====
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer for loads and runs: scan, per-neighbor root and weight, weighted
// accumulation, per-channel division, compare and emit.
// ----------------------------------------------------------------------------
module knn_ctrl
  import knn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic [1:0] in_func,
  output logic     in_ready,
  input  logic     out_busy,
  input  knn_sts_t sts,
  output knn_cmd_t cmd
);

  knn_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_RUN) begin
            cmd.run_start = 1'b1;
            state_next    = ST_SCAN;
          end else begin
            cmd.do_load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.root_start = 1'b1;
          state_next     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) begin
          cmd.wdiv_start = 1'b1;
          state_next     = ST_WDIV;
        end
      end
      ST_WDIV: begin
        cmd.wdiv_step = 1'b1;
        if (sts.wdiv_done) begin
          if (sts.nb_last) begin
            cmd.acc_start = 1'b1;
            state_next    = ST_ACC;
          end else begin
            cmd.root_start = 1'b1;
            state_next     = ST_ROOT;
          end
        end
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.acc_done) begin
          cmd.ediv_start = 1'b1;
          state_next     = ST_EDIV;
        end
      end
      ST_EDIV: begin
        cmd.ediv_step = 1'b1;
        if (sts.ediv_done) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp_step = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_busy) begin
          cmd.emit = 1'b1;
          if (sts.ch_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.acc_start = 1'b1;
            state_next    = ST_ACC;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== design/knn_dp.sv =====
// ----------------------------------------------------------------------------
// knn_dp
// Datapath: reference memories, neighbor list, bit-serial root and dividers,
// weighted accumulation and the output register.
// ----------------------------------------------------------------------------
module knn_dp
  import knn_pkg::*;
#(
  parameter int Neighbors = NeighborsDef,
  parameter int RefDepth  = RefDepthDef,
  parameter int Channels  = ChannelsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  knn_in_t             in_item,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  knn_cmd_t            cmd,
  output knn_sts_t            sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_busy,
  output knn_out_t            out_item
);

  localparam int EW  = (RefDepth > 1) ? $clog2(RefDepth) : 1;
  localparam int CW  = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int NW  = (Neighbors > 1) ? $clog2(Neighbors) : 1;
  localparam int FpDepth = RefDepth * Channels;
  localparam int FW  = (FpDepth > 1) ? $clog2(FpDepth) : 1;
  localparam int CntW = $clog2(RefDepth + 1);
  localparam int AW  = AccW;

  // Configuration registers.
  logic [10:0] ref_count;
  logic [15:0] ratio;
  logic [15:0] efloor;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      ratio     <= 16'd16384;
      efloor    <= 16'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_COUNT: ref_count <= cfg_data[10:0];
        CFG_RATIO:     ratio     <= cfg_data;
        CFG_FLOOR:     efloor    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] count_lim;
  assign count_lim = ({21'd0, ref_count} > RefDepth) ? CntW'(RefDepth)
                                                     : CntW'(ref_count);

  // Load decode.
  logic entry_ok, chan_ok;
  assign entry_ok = {22'd0, in_item.entry_index} < RefDepth;
  assign chan_ok  = {26'd0, in_item.channel_index} < Channels;

  // Memories.
  logic          pos_we;
  logic [EW-1:0] pos_raddr;
  logic [47:0]   pos_rdata;
  logic          fp_we;
  logic [FW-1:0] fp_waddr, fp_raddr;
  logic [31:0]   fp_rdata;
  logic          ms_we;
  logic [CW-1:0] ms_raddr;
  logic [31:0]   ms_rdata;

  assign pos_we = cmd.do_load && in_item.func == FUNC_LOAD_POS && entry_ok;
  assign fp_we  = cmd.do_load && in_item.func == FUNC_LOAD_FP && entry_ok && chan_ok;
  assign ms_we  = cmd.do_load && in_item.func == FUNC_LOAD_MEAS && chan_ok;
  assign fp_waddr = FW'(in_item.entry_index) * FW'(Channels) + FW'(in_item.channel_index);

  knn_ram #(.Width(48), .Depth(RefDepth)) u_pos (
    .clk, .we(pos_we), .waddr(in_item.entry_index[EW-1:0]),
    .wdata({in_item.coord_x, in_item.coord_y}),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );
  knn_ram #(.Width(32), .Depth(FpDepth)) u_fp (
    .clk, .we(fp_we), .waddr(fp_waddr), .wdata(in_item.intensity),
    .raddr(fp_raddr), .rdata(fp_rdata)
  );
  knn_ram #(.Width(32), .Depth(Channels)) u_ms (
    .clk, .we(ms_we), .waddr(in_item.channel_index[CW-1:0]),
    .wdata(in_item.intensity), .raddr(ms_raddr), .rdata(ms_rdata)
  );

  // ---------------- Scan ----------------
  // Pipeline: address issue -> data -> magnitudes -> squares -> update.
  logic signed [23:0] qx, qy;
  logic [CntW-1:0]    scan_addr;
  logic               v1, v2, v3;
  logic [CntW-1:0]    n1, n2, n3;
  logic [23:0]        dx2, dy2;
  logic [47:0]        sqx, sqy;
  logic [DistW-1:0]   bdist [Neighbors];
  logic [EW-1:0]      bent  [Neighbors];
  logic               bval  [Neighbors];
  logic [NW-1:0]      worst;

  logic signed [24:0] ddx, ddy;
  assign ddx = 25'(qx) - 25'(signed'(pos_rdata[47:24]));
  assign ddy = 25'(qy) - 25'(signed'(pos_rdata[23:0]));

  always_comb begin
    worst = '0;
    for (int k = 1; k < Neighbors; k++) begin
      if (bdist[k] > bdist[worst]) worst = NW'(k);
    end
  end

  logic [DistW-1:0] dsum;
  assign dsum = DistW'(sqx) + DistW'(sqy);

  logic scan_issue;
  assign scan_issue = cmd.scan_step && scan_addr < count_lim;
  assign sts.scan_done = cmd.scan_step && !(scan_addr < count_lim) && !v1 && !v2 && !v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int k = 0; k < Neighbors; k++) bval[k] <= 1'b0;
    end else if (cmd.run_start) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int k = 0; k < Neighbors; k++) begin
        bval[k]  <= 1'b0;
        bdist[k] <= '1;
      end
    end else begin
      v1 <= scan_issue;
      v2 <= v1;
      v3 <= v2;
      if (v3 && dsum < bdist[worst]) begin
        bdist[worst] <= dsum;
        bent[worst]  <= n3[EW-1:0];
        bval[worst]  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      qx        <= in_item.coord_x;
      qy        <= in_item.coord_y;
      scan_addr <= '0;
    end else if (scan_issue) begin
      scan_addr <= scan_addr + 1'b1;
    end
    n1  <= scan_addr;
    n2  <= n1;
    n3  <= n2;
    dx2 <= ddx[24] ? 24'(-ddx) : ddx[23:0];
    dy2 <= ddy[24] ? 24'(-ddy) : ddy[23:0];
    sqx <= 48'(dx2) * 48'(dx2);
    sqy <= 48'(dy2) * 48'(dy2);
  end
  // Note: dx2 captures the magnitude in the cycle after the read data; v2 marks it,
  // and v3 marks the squares in the cycle after that.

  // ---------------- Root and weight per neighbor ----------------
  logic [NW-1:0]    nb;
  logic [DistW-1:0] rrem;
  logic [RootW-1:0] rroot;
  logic [4:0]       rcnt;
  logic [WeightW-1:0] wgt [Neighbors];
  logic [WsumW-1:0] wsum;

  logic [DistW-1:0] rtrial;
  logic [DistW-1:0] rsrc;
  assign rtrial = {rrem[DistW-3:0], rsrc[DistW-1:DistW-2]};
  logic [DistW-1:0] rtest;
  assign rtest = DistW'({rroot, 2'b01});
  logic [DistW-1:0] rdist_sh;
  logic [DistW-1:0] rrem_next;
  logic [RootW-1:0] rroot_next;
  logic [NW-1:0]    rnb;

  // A root started from the weight stage belongs to the following neighbor.
  assign rnb = cmd.wdiv_step ? NW'(nb + 1'b1) : nb;

  assign sts.root_done = cmd.root_step && rcnt == 5'd24;
  assign sts.nb_last   = nb == NW'(Neighbors - 1);

  always_comb begin
    if (rtrial >= rtest) begin
      rrem_next  = rtrial - rtest;
      rroot_next = {rroot[RootW-2:0], 1'b1};
    end else begin
      rrem_next  = rtrial;
      rroot_next = {rroot[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rrem     <= '0;
      rroot    <= '0;
      rcnt     <= '0;
      rdist_sh <= bdist[rnb];
    end else if (cmd.root_step) begin
      rcnt     <= rcnt + 1'b1;
      rdist_sh <= {rdist_sh[DistW-3:0], 2'b00};
      rrem     <= rrem_next;
      rroot    <= rroot_next;
    end
  end
  assign rsrc = rdist_sh;

  // Weight divider: 2^24 / r, restoring, 25 quotient bits.
  logic [RootW-1:0]   dvs;
  logic [25:0]        wrem;
  logic [WeightW-1:0] wq;
  logic [4:0]         wcnt;
  logic [25:0]        wtrial;
  assign wtrial = {wrem[24:0], wq[WeightW-1]};
  assign sts.wdiv_done = cmd.wdiv_step && wcnt == 5'd24;

  logic [WeightW-1:0] wq_next;
  logic [25:0]        wrem_next;
  always_comb begin
    if (wtrial >= 26'(dvs)) begin
      wrem_next = wtrial - 26'(dvs);
      wq_next   = {wq[WeightW-2:0], 1'b1};
    end else begin
      wrem_next = wtrial;
      wq_next   = {wq[WeightW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      nb   <= '0;
      wsum <= '0;
    end
    if (cmd.wdiv_start) begin
      // The root takes its last bit at this edge, so the divisor comes from it.
      dvs  <= (rroot_next == '0) ? RootW'(1) : rroot_next;
      wrem <= '0;
      wq   <= WeightW'(1) << 24;
      wcnt <= '0;
    end else if (cmd.wdiv_step) begin
      wcnt <= wcnt + 1'b1;
      wrem <= wrem_next;
      wq   <= wq_next;
      if (wcnt == 5'd24) begin
        if (bval[nb]) begin
          wgt[nb] <= (wq_next == '0) ? WeightW'(1) : wq_next;
          wsum    <= wsum + WsumW'((wq_next == '0) ? WeightW'(1) : wq_next);
        end else begin
          wgt[nb] <= '0;
        end
        nb <= nb + 1'b1;
      end
    end
  end

  // ---------------- Per-channel accumulation ----------------
  logic [CW-1:0]  ch;
  logic [NW:0]    an;      // neighbor being issued
  logic           av1, av2;
  logic [NW-1:0]  ak1;
  logic [AW-1:0]  acc;
  logic [56:0]    prod;
  logic           aissue;
  logic [NW-1:0]  an_idx;
  assign an_idx = an[NW-1:0];
  assign aissue = cmd.acc_step && an < (NW+1)'(Neighbors);
  assign sts.acc_done = cmd.acc_step && !aissue && !av1 && !av2;
  assign fp_raddr = FW'(bent[an_idx]) * FW'(Channels) + FW'(ch);
  assign ms_raddr = ch;
  assign sts.ch_last = ch == CW'(Channels - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      av1 <= 1'b0;
      av2 <= 1'b0;
    end else begin
      av1 <= aissue;
      av2 <= av1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) ch <= '0;
    else if (cmd.emit) ch <= ch + 1'b1;
    if (cmd.acc_start) begin
      an  <= '0;
      acc <= '0;
    end else begin
      if (aissue) an <= an + 1'b1;
      if (av2) acc <= acc + AW'(prod);
    end
    ak1  <= an_idx;
    // An empty neighbor slot contributes nothing, whatever its entry reads.
    prod <= bval[ak1] ? 57'(fp_rdata) * 57'(wgt[ak1]) : '0;
  end

  // ---------------- Expected = acc / wsum ----------------
  logic [AW-1:0]   eq;
  logic [WsumW:0]  erem;
  logic [5:0]      ecnt;
  logic [WsumW:0]  etrial;
  assign etrial = {erem[WsumW-1:0], eq[AW-1]};
  assign sts.ediv_done = cmd.ediv_step && ecnt == 6'(AW - 1);

  always_ff @(posedge clk) begin
    if (cmd.ediv_start) begin
      eq   <= acc;
      erem <= '0;
      ecnt <= '0;
    end else if (cmd.ediv_step) begin
      ecnt <= ecnt + 1'b1;
      if (etrial >= (WsumW+1)'(wsum)) begin
        erem <= etrial - (WsumW+1)'(wsum);
        eq   <= {eq[AW-2:0], 1'b1};
      end else begin
        erem <= etrial;
        eq   <= {eq[AW-2:0], 1'b0};
      end
    end
  end

  // ---------------- Compare and emit ----------------
  logic [AW-1:0]  e_q;
  logic [47:0]    m_sh;
  logic [77:0]    thr;
  logic           rep;
  logic [5:0]     total;

  always_ff @(posedge clk) begin
    if (cmd.cmp_step) begin
      e_q  <= eq;
      m_sh <= {ms_rdata, 16'd0};
      thr  <= 78'(ratio) * 78'(eq);
    end
  end
  assign rep = (wsum != '0) && (e_q > AW'(efloor)) && (78'(m_sh) < thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.run_start) total <= '0;
    if (cmd.emit) begin
      out_item.channel_out        <= 6'(ch);
      out_item.repaired_intensity <= rep ? e_q[31:0] : m_sh[47:16];
      out_item.was_replaced       <= rep;
      out_item.replaced_total     <= total + 6'(rep);
      out_item.last               <= sts.ch_last;
      total                       <= total + 6'(rep);
    end
  end

  // Scan address goes to the position memory.
  assign pos_raddr = scan_addr[EW-1:0];

endmodule

// ===== design/knn_fingerprint_repair_unit.sv =====
// A run scans the first ref_count entries (at most RefDepth), then takes a root and
// a weight division per neighbor, then per channel accumulates, divides, compares and emits.
// Each load is written in the cycle it is accepted; a run blocks new items until its
// last result is loaded into the output register. One bit-serial divider serves every channel.
// Reset (rst, synchronous) clears control state and loads the configuration defaults.
// ----------------------------------------------------------------------------
// knn_fingerprint_repair_unit
// Top level: inverse-distance-weighted nearest neighbor fingerprint repair.
// ----------------------------------------------------------------------------
module knn_fingerprint_repair_unit
  import knn_pkg::*;
#(
  parameter int Neighbors = NeighborsDef,
  parameter int RefDepth  = RefDepthDef,
  parameter int Channels  = ChannelsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  knn_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output knn_out_t            out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // The controller sequences each item; the datapath holds all storage.
  knn_cmd_t cmd;
  knn_sts_t sts;
  logic     out_busy;

  knn_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_func(in_data.func), .in_ready,
    .out_busy, .sts, .cmd
  );

  knn_dp #(.Neighbors(Neighbors), .RefDepth(RefDepth), .Channels(Channels)) u_dp (
    .clk, .rst, .in_item(in_data), .cfg_we, .cfg_index, .cfg_data,
    .cmd, .sts, .out_valid, .out_ready, .out_busy, .out_item(out_data)
  );

endmodule

// ===== sim/knn_fingerprint_repair_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_fingerprint_repair_unit_test
// Self-checking bench: loads references and measurements, runs repair queries
// and checks every channel against a built-in repair predictor or the plain measurement.
// ----------------------------------------------------------------------------
module knn_fingerprint_repair_unit_test;
  import knn_pkg::*;

  localparam int NB        = NeighborsDef;
  localparam int DEPTH     = RefDepthDef;
  localparam int CH        = ChannelsDef;
  localparam int IDLE_MAX  = 20000;  // cycles in which no item moves on either side
  localparam int SETTLE    = 8;      // cycles after the last result before a config write
  localparam int HOLD_OFF  = 400;    // long receiver stall used to back the block up
  localparam int RAND_ITEMS = 150;
  localparam int QUIET_TAIL = 30;    // last random items sent without idling

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef struct {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    knn_in_t             item;
    bit                  passthrough;  // run result is simply the stored measurement
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  knn_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  knn_out_t            out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Mirror of the block's stores and registers, updated as items are accepted.
  logic signed [23:0] ref_x [DEPTH];
  logic signed [23:0] ref_y [DEPTH];
  logic [31:0]        ref_fp [DEPTH*CH];
  logic [31:0]        meas [CH];
  logic [10:0]        ref_count;
  logic [15:0]        ratio;
  logic [15:0]        exp_floor;

  knn_out_t pending_channels[$];
  int       mismatches = 0;
  bit       quiet = 1'b0;       // no idling on either side
  bit       literal_run = 1'b0; // next run is checked against the plain measurement
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;
  int       rx_wait = 0;
  int       idle_cycles = 0;

  knn_fingerprint_repair_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Floor of the square root, one result bit at a time.
  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res;
    longint unsigned cand;
    res = 0;
    for (int b = 25; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // Expected channels of one repair run at query (qx, qy).
  function automatic void predict_repair(input logic signed [23:0] qx,
                                         input logic signed [23:0] qy);
    longint unsigned near_dist [NB];
    int              near_idx [NB];
    bit              near_ok [NB];
    longint unsigned acc [CH];
    longint unsigned wsum, d, r, w, e;
    longint          dxs, dys;
    int              cnt, worst, total;
    knn_out_t        o;
    cnt = (ref_count > DEPTH) ? DEPTH : int'(ref_count);
    for (int k = 0; k < NB; k++) begin
      near_dist[k] = (64'd1 << 50) - 1;
      near_idx[k]  = 0;
      near_ok[k]   = 1'b0;
    end
    for (int n = 0; n < cnt; n++) begin
      dxs = longint'(qx) - longint'(ref_x[n]);
      dys = longint'(qy) - longint'(ref_y[n]);
      if (dxs < 0) dxs = -dxs;
      if (dys < 0) dys = -dys;
      d = longint'(dxs * dxs + dys * dys);
      // Only a strictly closer candidate displaces the first-found worst slot.
      worst = 0;
      for (int k = 1; k < NB; k++)
        if (near_dist[k] > near_dist[worst]) worst = k;
      if (d < near_dist[worst]) begin
        near_dist[worst] = d;
        near_idx[worst]  = n;
        near_ok[worst]   = 1'b1;
      end
    end
    wsum = 0;
    for (int i = 0; i < CH; i++) acc[i] = 0;
    for (int k = 0; k < NB; k++) begin
      if (near_ok[k]) begin
        r = int_root(near_dist[k]);
        if (r < 1) r = 1;
        w = (64'd1 << 24) / r;
        if (w < 1) w = 1;
        wsum += w;
        for (int i = 0; i < CH; i++)
          acc[i] += longint'(ref_fp[near_idx[k]*CH + i]) * w;
      end
    end
    total = 0;
    for (int i = 0; i < CH; i++) begin
      o = '0;
      o.channel_out        = i[5:0];
      o.repaired_intensity = meas[i];
      if (wsum != 0) begin
        e = acc[i] / wsum;
        if (e > longint'(exp_floor) &&
            (longint'(meas[i]) << 16) < longint'(ratio) * e) begin
          o.repaired_intensity = e[31:0];
          o.was_replaced       = 1'b1;
          total++;
        end
      end
      o.replaced_total = total[5:0];
      o.last           = (i == CH - 1);
      pending_channels.push_back(o);
    end
  endfunction

  // Every accepted item updates the mirror or queues the channels it causes.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      case (in_data.func)
        FUNC_LOAD_POS: begin
          ref_x[in_data.entry_index] = in_data.coord_x;
          ref_y[in_data.entry_index] = in_data.coord_y;
        end
        FUNC_LOAD_FP: begin
          if (in_data.channel_index < CH)
            ref_fp[int'(in_data.entry_index)*CH + in_data.channel_index] = in_data.intensity;
        end
        FUNC_LOAD_MEAS: begin
          if (in_data.channel_index < CH) meas[in_data.channel_index] = in_data.intensity;
        end
        default: begin
          if (literal_run) begin
            // Nothing may be replaced: each channel comes back as measured.
            for (int i = 0; i < CH; i++)
              pending_channels.push_back('{channel_out: i[5:0], repaired_intensity: meas[i],
                                           was_replaced: 1'b0, replaced_total: 6'd0,
                                           last: (i == CH - 1)});
          end else begin
            predict_repair(in_data.coord_x, in_data.coord_y);
          end
        end
      endcase
    end
  end

  // Each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    knn_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_channels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ch %0d val %h rep %0d tot %0d last %0d",
                   out_data.channel_out, out_data.repaired_intensity,
                   out_data.was_replaced, out_data.replaced_total, out_data.last);
      end else begin
        want = pending_channels.pop_front();
        if (out_data.channel_out !== want.channel_out ||
            out_data.repaired_intensity !== want.repaired_intensity ||
            out_data.was_replaced !== want.was_replaced ||
            out_data.replaced_total !== want.replaced_total ||
            out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp ch %0d val %h rep %0d tot %0d last %0d",
                     want.channel_out, want.repaired_intensity, want.was_replaced,
                     want.replaced_total, want.last);
            $display("          got ch %0d val %h rep %0d tot %0d last %0d",
                     out_data.channel_out, out_data.repaired_intensity,
                     out_data.was_replaced, out_data.replaced_total, out_data.last);
          end
        end
      end
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      rx_wait   <= HOLD_OFF;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_wait   <= $urandom_range(1, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("knn_fingerprint_repair_unit test failed");
      $finish;
    end
  end

  // Offers one item, with an occasional random gap first; valid stays high after.
  task automatic send_item(input knn_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lets every expected result drain, then waits out SETTLE for trailing loads.
  // The first edge lets the monitor queue the channels of an item just accepted.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_channels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REF_COUNT: ref_count = val[10:0];
      CFG_RATIO:     ratio     = val;
      CFG_FLOOR:     exp_floor = val;
      default: ;
    endcase
  endtask

  function automatic knn_in_t mk(input logic [1:0] f, input int entry, input int chan,
                                 input logic [31:0] val, input int x, input int y);
    knn_in_t it;
    it.func          = f;
    it.entry_index   = entry[9:0];
    it.channel_index = chan[5:0];
    it.intensity     = val;
    it.coord_x       = x[23:0];
    it.coord_y       = y[23:0];
    return it;
  endfunction

  function automatic logic [31:0] rand_intensity();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 255);
      2:       return $urandom_range(0, 32'h000F_FFFF);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return int'($urandom);
    return $signed($urandom_range(0, 65535)) - 32768;
  endfunction

  // Mostly loads into the searched entries, some stray channels, some runs.
  function automatic knn_in_t rand_item();
    int pick;
    int entry;
    int chan;
    pick  = $urandom_range(0, 99);
    entry = ($urandom_range(0, 4) == 0) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, 7);
    chan  = ($urandom_range(0, 9) == 0) ? $urandom_range(CH, 63) : $urandom_range(0, CH - 1);
    if (pick < 10) return mk(FUNC_RUN, $urandom, $urandom, $urandom, rand_coord(), rand_coord());
    if (pick < 25) return mk(FUNC_LOAD_POS, entry, $urandom, $urandom, rand_coord(), rand_coord());
    if (pick < 60) return mk(FUNC_LOAD_FP, entry, chan, rand_intensity(), $urandom, $urandom);
    return mk(FUNC_LOAD_MEAS, $urandom, chan, rand_intensity(), $urandom, $urandom);
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;

    ref_count = 11'd0;
    ratio     = 16'd16384;
    exp_floor = 16'd7;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the measurement and the first eight reference entries completely,
    // so that no run ever reads a table entry that was never written.
    for (int c = 0; c < CH; c++) send_item(mk(FUNC_LOAD_MEAS, 0, c, rand_intensity(), 0, 0));
    for (int n = 0; n < 8; n++) begin
      send_item(mk(FUNC_LOAD_POS, n, 0, 0, rand_coord(), rand_coord()));
      for (int c = 0; c < CH; c++) send_item(mk(FUNC_LOAD_FP, n, c, rand_intensity(), 0, 0));
    end

    // Directed rows.
    row = '{ROW_ITEM, CFG_REF_COUNT, 16'd0, mk(FUNC_RUN, 0, 0, 0, 0, 0), 1'b1};
    rows.push_back(row);  // empty search after reset: measurement passes through
    row = '{ROW_CFG, CFG_REF_COUNT, 16'd8, '0, 1'b0};
    rows.push_back(row);
    row.kind = ROW_ITEM; row.passthrough = 1'b0;
    row.item = mk(FUNC_RUN, 0, 0, 0, -8388608, -8388608); rows.push_back(row);
    row.item = mk(FUNC_RUN, 0, 0, 0, 8388607, 8388607);   rows.push_back(row);
    // Two entries at the same spot as the query: both are found at distance zero.
    row.item = mk(FUNC_LOAD_POS, 4, 0, 0, 1000, 1000);    rows.push_back(row);
    row.item = mk(FUNC_LOAD_POS, 5, 0, 0, 1000, 1000);    rows.push_back(row);
    row.item = mk(FUNC_RUN, 0, 0, 0, 1000, 1000);         rows.push_back(row);
    row.item = mk(FUNC_LOAD_MEAS, 0, 0, 32'h0, 0, 0);         rows.push_back(row);
    row.item = mk(FUNC_LOAD_MEAS, 0, 35, 32'hFFFF_FFFF, 0, 0); rows.push_back(row);
    row.item = mk(FUNC_LOAD_FP, 1023, 0, 32'hFFFF_FFFF, 0, 0); rows.push_back(row);
    row.item = mk(FUNC_LOAD_POS, 1023, 0, 0, -8388608, 8388607); rows.push_back(row);
    // Channel indexes past the end are dropped.
    row.item = mk(FUNC_LOAD_FP, 0, 36, 32'hFFFF_FFFF, 0, 0);   rows.push_back(row);
    row.item = mk(FUNC_LOAD_MEAS, 0, 63, 32'hFFFF_FFFF, 0, 0); rows.push_back(row);
    row.item = mk(FUNC_LOAD_FP, 2, 35, 32'h0, 0, 0);           rows.push_back(row);
    row = '{ROW_CFG, CFG_RATIO, 16'hFFFF, '0, 1'b0}; rows.push_back(row);
    row = '{ROW_CFG, CFG_FLOOR, 16'd0, '0, 1'b0};    rows.push_back(row);
    row = '{ROW_ITEM, CFG_REF_COUNT, 16'd0, mk(FUNC_RUN, 0, 0, 0, 0, 0), 1'b0};
    rows.push_back(row);
    // A zero ratio can never trigger a replacement.
    row = '{ROW_CFG, CFG_RATIO, 16'd0, '0, 1'b0}; rows.push_back(row);
    row = '{ROW_ITEM, CFG_REF_COUNT, 16'd0, mk(FUNC_RUN, 0, 0, 0, 500, -500), 1'b1};
    rows.push_back(row);
    row = '{ROW_CFG, CFG_FLOOR, 16'hFFFF, '0, 1'b0};  rows.push_back(row);
    row = '{ROW_CFG, CFG_RATIO, 16'd16384, '0, 1'b0}; rows.push_back(row);
    row = '{ROW_ITEM, CFG_REF_COUNT, 16'd0, mk(FUNC_RUN, 0, 0, 0, 0, 0), 1'b0};
    rows.push_back(row);
    row = '{ROW_CFG, CFG_REF_COUNT, 16'd1, '0, 1'b0}; rows.push_back(row);
    row = '{ROW_ITEM, CFG_REF_COUNT, 16'd0, mk(FUNC_RUN, 0, 0, 0, 77, 77), 1'b0};
    rows.push_back(row);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_block();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        if (rows[i].passthrough) begin
          drain_block();
          literal_run = 1'b1;
        end
        send_item(rows[i].item);
        if (rows[i].passthrough) begin
          drain_block();
          literal_run = 1'b0;
        end
      end
    end

    // Random part, with a new register setting every so often; the tail has no idling.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) begin
        drain_block();
        write_reg(CFG_REF_COUNT, 16'($urandom_range(0, 8)));
        write_reg(CFG_RATIO, 16'($urandom));
        write_reg(CFG_FLOOR, 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                              : $urandom));
      end
      if (i == 50) hold_req = 1'b1;
      if (i == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      send_item(rand_item());
    end

    // Closing runs over all searched entries with the loosest thresholds.
    drain_block();
    write_reg(CFG_REF_COUNT, 16'd8);
    write_reg(CFG_RATIO, 16'hFFFF);
    write_reg(CFG_FLOOR, 16'd0);
    send_item(mk(FUNC_RUN, 0, 0, 0, rand_coord(), rand_coord()));
    send_item(mk(FUNC_RUN, 0, 0, 0, -8388608, 8388607));
    drain_block();
    repeat (200) @(posedge clk);

    if (mismatches == 0 && pending_channels.size() == 0) begin
      $display("knn_fingerprint_repair_unit test passed");
    end else begin
      $display("knn_fingerprint_repair_unit test failed");
    end
    $finish;
  end

endmodule
